// ===== rtl/core/iirl_pkg.sv =====
package iirl_pkg;

    // Wide enough for any list index or count up to the largest supported capacity.
    localparam int POS_W = 7;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_RANGE = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;
    localparam logic [1:0] STS_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   tail;
    } t_cell_ctrl;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [4:0]         position;
        logic signed [31:0] item_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic signed [31:0] read_value;
        logic               last;
    } t_out_word;

endpackage

// ===== rtl/core/iirl_cell.sv =====
module iirl_cell
    import iirl_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_head,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    output logic signed [31:0] o_data
);

    localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
                n_data = r_data;
            end
            CELL_INSERT: begin
                // Cells past the insert point take the left neighbor's word.
                if (IDX_P > i_ctrl.pos) begin
                    n_data = i_left;
                end else if (IDX_P == i_ctrl.pos) begin
                    n_data = i_value;
                end
            end
            CELL_REMOVE: begin
                if (IDX_P >= i_ctrl.pos) begin
                    n_data = i_right;
                end
            end
            CELL_ROTATE: begin
                // The tail cell wraps the head word around; the rest advance down.
                if (IDX_P == i_ctrl.tail) begin
                    n_data = i_head;
                end else begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/core/indexed_insert_remove_list_core.sv =====
// Channel   Valid        Stall        Word
// in        i_in_valid   o_in_stall   i_in_word  (t_in_word)
// out       o_out_valid  i_out_stall  o_out_word (t_out_word)
//
// Insert and remove requests shift the chain in place, in the same edge that
// registers the status word; during a dump the chain rotates one place per
// emitted word. Reset (synchronous, active low) clears the count, the state
// and the output valid; cell contents are not reset. A stalled output holds
// the word and stalls the input side.
module indexed_insert_remove_list_core
    import iirl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_dump_idx, n_dump_idx;
    logic           r_out_valid, n_out_valid;
    t_out_word      r_out_word, n_out_word;

    t_cell_ctrl         w_ctrl;
    logic signed [31:0] w_data [CAPACITY];

    logic               w_out_free;
    logic               w_in_accept;
    logic [POS_W-1:0]   w_pos;
    logic [POS_W-1:0]   w_cnt;
    logic               w_dump_last;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE) || !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_pos       = POS_W'(i_in_word.position);
    assign w_cnt       = POS_W'(r_count);
    assign w_dump_last = (r_dump_idx == (r_count - CW'(1)));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dump_idx  = r_dump_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        w_ctrl.op   = CELL_HOLD;
        w_ctrl.pos  = w_pos;
        w_ctrl.tail = w_cnt - POS_W'(1);

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_out_word.read_value = '0;
                    n_out_word.last       = 1'b1;
                    n_out_word.status     = STS_OK;
                    n_out_valid           = 1'b1;
                    unique case (i_in_word.req_type)
                        REQ_INSERT: begin
                            if (w_pos > w_cnt) begin
                                n_out_word.status = STS_RANGE;
                            end else if (w_cnt == POS_W'(CAPACITY)) begin
                                n_out_word.status = STS_FULL;
                            end else begin
                                w_ctrl.op = CELL_INSERT;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            if (w_pos >= w_cnt) begin
                                n_out_word.status = STS_RANGE;
                            end else begin
                                w_ctrl.op = CELL_REMOVE;
                                n_count   = r_count - CW'(1);
                            end
                        end
                        REQ_DUMP: begin
                            if (r_count == '0) begin
                                n_out_word.status = STS_EMPTY;
                            end else begin
                                // Hold the output empty; words come from the dump state.
                                n_out_valid = 1'b0;
                                n_state     = ST_DUMP;
                                n_dump_idx  = '0;
                            end
                        end
                        default: begin
                            n_out_word.status = STS_RANGE;
                        end
                    endcase
                    n_out_word.entry_count = 5'(n_count);
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_word.status      = STS_OK;
                    n_out_word.entry_count = 5'(r_count);
                    n_out_word.read_value  = w_data[0];
                    n_out_word.last        = w_dump_last;
                    w_ctrl.op              = CELL_ROTATE;
                    n_dump_idx             = r_dump_idx + CW'(1);
                    if (w_dump_last) begin
                        n_state    = ST_IDLE;
                        n_dump_idx = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dump_idx  <= n_dump_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        iirl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_value (i_in_word.item_value),
            .i_head  (w_data[0]),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        POS_W'(r_count) <= POS_W'(CAPACITY))
        else $error("list count above capacity");

    a_dump_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> o_in_stall)
        else $error("input accepted during dump");

    a_dump_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |=> (r_count == $past(r_count)))
        else $error("count changed during dump");

    a_value_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.status != STS_OK)) |-> (r_out_word.read_value == '0))
        else $error("rejected word carries a value");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

// Tracks the expected list contents and the queue of expected output words.
class list_scoreboard;
    int                  capacity;
    int unsigned         errors;
    logic signed [31:0]  cells[$];
    iirl_pkg::t_out_word awaited[$];

    function new(int cap);
        capacity = cap;
        errors   = 0;
    endfunction

    function int size();
        return cells.size();
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void push_word(logic [1:0] status, logic signed [31:0] value, logic last);
        iirl_pkg::t_out_word w;
        w.status      = status;
        w.entry_count = 5'(cells.size());
        w.read_value  = value;
        w.last        = last;
        awaited.push_back(w);
    endfunction

    function void note_request(iirl_pkg::t_in_word w);
        int pos;
        pos = int'(w.position);
        case (w.req_type)
            iirl_pkg::REQ_INSERT: begin
                // index test wins over the full test
                if (pos > cells.size()) begin
                    push_word(iirl_pkg::STS_RANGE, 32'sd0, 1'b1);
                end else if (cells.size() >= capacity) begin
                    push_word(iirl_pkg::STS_FULL, 32'sd0, 1'b1);
                end else begin
                    cells.insert(pos, w.item_value);
                    push_word(iirl_pkg::STS_OK, 32'sd0, 1'b1);
                end
            end
            iirl_pkg::REQ_REMOVE: begin
                if (pos >= cells.size()) begin
                    push_word(iirl_pkg::STS_RANGE, 32'sd0, 1'b1);
                end else begin
                    cells.delete(pos);
                    push_word(iirl_pkg::STS_OK, 32'sd0, 1'b1);
                end
            end
            iirl_pkg::REQ_DUMP: begin
                if (cells.size() == 0) begin
                    push_word(iirl_pkg::STS_EMPTY, 32'sd0, 1'b1);
                end else begin
                    foreach (cells[i])
                        push_word(iirl_pkg::STS_OK, cells[i], 1'(i == cells.size() - 1));
                end
            end
            default: begin
                push_word(iirl_pkg::STS_RANGE, 32'sd0, 1'b1);
            end
        endcase
    endfunction

    function void check_result(iirl_pkg::t_out_word got);
        iirl_pkg::t_out_word exp;
        if (awaited.size() == 0) begin
            $error("unexpected output word: status %0d count %0d value %0d last %0d",
                   got.status, got.entry_count, got.read_value, got.last);
            errors++;
            return;
        end
        exp = awaited.pop_front();
        if (got.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, got.status);
            errors++;
        end
        if (got.entry_count !== exp.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", exp.entry_count, got.entry_count);
            errors++;
        end
        if (got.read_value !== exp.read_value) begin
            $error("read_value: expected %0d, actual %0d", exp.read_value, got.read_value);
            errors++;
        end
        if (got.last !== exp.last) begin
            $error("last: expected %0d, actual %0d", exp.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import iirl_pkg::*;

    localparam int CAPACITY = 16;

    typedef enum {
        BIAS_GROW,
        BIAS_SHRINK,
        BIAS_CHURN
    } t_bias;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    list_scoreboard sb = new(CAPACITY);

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_request = 0;
    int hold_left    = 0;

    indexed_insert_remove_list_core #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_out_stall <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_word);
    end

    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(w);
    endtask

    task automatic send_fields(input logic [1:0] kind, input int pos, input logic [31:0] value);
        t_in_word w;
        w.req_type   = kind;
        w.position   = 5'(pos);
        w.item_value = value;
        send_word(w);
    endtask

    function automatic t_in_word make_request(t_bias bias);
        t_in_word w;
        int       r;
        int       grow_pct;
        w.req_type   = REQ_DUMP;
        w.position   = 5'($urandom_range(0, 31));
        w.item_value = $urandom;
        r = $urandom_range(0, 99);
        case (bias)
            BIAS_GROW:   grow_pct = 90;
            BIAS_SHRINK: grow_pct = 15;
            default:     grow_pct = 50;
        endcase
        if (r < 8) begin
            // noise: any type, any position
            w.req_type = 2'($urandom_range(0, 3));
        end else if (r >= 20) begin
            if ($urandom_range(0, 99) < grow_pct) begin
                w.req_type = REQ_INSERT;
                w.position = 5'($urandom_range(0, sb.size()));
            end else begin
                w.req_type = REQ_REMOVE;
                if (sb.size() > 0)
                    w.position = 5'($urandom_range(0, sb.size() - 1));
            end
        end
        return w;
    endfunction

    task automatic run_blocks(input int n_items);
        t_bias bias;
        int    left;
        bias = BIAS_GROW;
        while (n_items > 0) begin
            left = $urandom_range(8, 24);
            if (bias == BIAS_GROW)
                left = 24;
            while (left > 0 && n_items > 0) begin
                send_word(make_request(bias));
                left--;
                n_items--;
            end
            case (bias)
                BIAS_GROW:   bias = BIAS_SHRINK;
                BIAS_SHRINK: bias = BIAS_CHURN;
                default:     bias = BIAS_GROW;
            endcase
        end
    endtask

    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // empty list cases, unused type, value extremes, bad indices
        send_fields(REQ_DUMP,    0, 32'h0);
        send_fields(REQ_REMOVE,  0, 32'h0);
        send_fields(REQ_INSERT,  1, 32'h1234_5678);
        send_fields(REQ_UNUSED, 31, 32'hFFFF_FFFF);
        send_fields(REQ_INSERT,  0, 32'h8000_0000);
        send_fields(REQ_INSERT,  1, 32'h7FFF_FFFF);
        send_fields(REQ_INSERT,  0, 32'hFFFF_FFFF);
        send_fields(REQ_INSERT,  3, 32'h0);
        send_fields(REQ_INSERT,  2, 32'h5555_5555);
        send_fields(REQ_INSERT,  6, 32'hAAAA_AAAA);
        send_fields(REQ_INSERT, 16, 32'h1);
        send_fields(REQ_DUMP,   31, 32'hFFFF_FFFF);
        send_fields(REQ_REMOVE,  5, 32'h0);
        send_fields(REQ_REMOVE, 31, 32'h0);
        send_fields(REQ_REMOVE,  2, 32'h0);
        send_fields(REQ_REMOVE,  3, 32'h0);
        send_fields(REQ_REMOVE,  0, 32'h0);
        send_fields(REQ_DUMP,    0, 32'h0);
        send_fields(REQ_UNUSED,  0, 32'h0);
        send_fields(REQ_REMOVE,  1, 32'h0);
        send_fields(REQ_REMOVE,  0, 32'h0);
        send_fields(REQ_DUMP,    0, 32'h0);

        tx_idle_pct = 20;
        rx_idle_pct = 51;
        run_blocks(63);

        tx_idle_pct = 51;
        rx_idle_pct = 20;
        run_blocks(63);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // hold the output long enough that the input side backs up
        hold_request = 300;
        run_blocks(63);

        i_in_valid <= 1'b0;
        n = 0;
        while (sb.pending() > 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (sb.pending() > 0) begin
            $error("%0d expected output words never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
